// File: hdl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg - shared types and constants
// Request and result records, sequencer states and divide-by-ten constants
// for the padded decimal formatter.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam logic [7:0]  ASCII_ZERO  = 8'd48;
    // reciprocal of ten, scaled by 2^35; exact for every 32-bit dividend
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  width;
        logic [7:0]  fill_char;
    } t_req;

    typedef struct packed {
        logic [3:0] position;
        logic [7:0] character;
        logic       last;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TERM,
        S_DIGIT,
        S_PAD
    } t_state;

    // sequencer to divide unit
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // divide unit to sequencer
    typedef struct packed {
        logic [3:0] digit;
        logic       quot_zero;
    } t_div_sts;

endpackage

// File: hdl/bpd_div10.sv
// ----------------------------------------------------------------------------
// bpd_div10 - shared divide-by-ten unit
// Holds the running value and its quotient by ten; each step shifts one
// decimal digit out, the remainder is formed from the registered pair.
// ----------------------------------------------------------------------------
module bpd_div10
    import bpd_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_value,
    input  t_div_ctl    i_ctl,
    output t_div_sts    o_sts
);

    logic [31:0] r_v;
    logic [31:0] r_q;
    logic [31:0] mul_op;
    logic [63:0] prod;
    logic [31:0] quot;
    logic [3:0]  q_x8;
    logic [3:0]  q_x2;

    // one multiplier, fed either by a new value or by the last quotient
    assign mul_op = i_ctl.load ? i_value : r_q;
    assign prod   = mul_op * RECIP_TEN;
    assign quot   = 32'(prod >> RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.step) begin
            r_v <= mul_op;
            r_q <= quot;
        end
    end

    // remainder below ten, so the low four bits of v - 10q are enough
    assign q_x8 = {r_q[0], 3'b000};
    assign q_x2 = {r_q[2:0], 1'b0};

    assign o_sts.digit     = r_v[3:0] - q_x8 - q_x2;
    assign o_sts.quot_zero = (r_q == 32'd0);

endmodule

// File: hdl/bpd_seq.sv
// ----------------------------------------------------------------------------
// bpd_seq - formatter sequencer
// Walks one request through terminator, digit and pad phases, one result
// per cycle, and steps the divide unit once per digit.
// ----------------------------------------------------------------------------
module bpd_seq
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH = 10
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_req     i_req,
    input  t_div_sts i_sts,
    output t_div_ctl o_ctl,
    output logic     o_busy,
    output logic     o_strobe,
    output t_rsp     o_rsp
);

    t_state     r_state, n_state;
    logic [3:0] r_left,  n_left;
    logic [7:0] r_pad,   n_pad;
    logic [3:0] w_sat;
    logic [3:0] left_dec;
    logic       more_digits;
    logic       more_pad;

    assign w_sat       = (int'(i_req.width) > MAX_WIDTH) ? 4'(MAX_WIDTH) : i_req.width;
    assign left_dec    = r_left - 4'd1;
    assign more_digits = !i_sts.quot_zero && (left_dec != 4'd0);
    assign more_pad    = (r_pad != 8'd0) && (left_dec != 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_left <= n_left;
        r_pad  <= n_pad;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_pad   = r_pad;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_TERM;
                    n_left  = w_sat;
                    n_pad   = i_req.fill_char;
                end
            end
            S_TERM: begin
                n_state = (r_left == 4'd0) ? S_IDLE : S_DIGIT;
            end
            S_DIGIT: begin
                n_left = left_dec;
                priority if (more_digits) begin
                    n_state = S_DIGIT;
                end else if (more_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                n_left = left_dec;
                if (left_dec == 4'd0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctl.load      = 1'b0;
        o_ctl.step      = 1'b0;
        o_busy          = 1'b1;
        o_strobe        = 1'b1;
        o_rsp.position  = left_dec;
        o_rsp.character = 8'd0;
        o_rsp.last      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_strobe   = 1'b0;
                o_ctl.load = i_start;
            end
            S_TERM: begin
                o_rsp.position = r_left;
                o_rsp.last     = (r_left == 4'd0);
            end
            S_DIGIT: begin
                o_ctl.step      = 1'b1;
                o_rsp.character = ASCII_ZERO + {4'd0, i_sts.digit};
                o_rsp.last      = !more_digits && !more_pad;
            end
            S_PAD: begin
                o_rsp.character = r_pad;
                o_rsp.last      = (left_dec == 4'd0);
            end
            default: begin
                o_strobe = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/binary_to_padded_decimal.sv
// ----------------------------------------------------------------------------
// binary_to_padded_decimal - right-aligned decimal ASCII formatter
// Turns a 32-bit unsigned value into right-aligned ASCII characters with
// their buffer positions, padded on the left when a pad character is given.
// ----------------------------------------------------------------------------
// usage: raise start with a request while busy is low. the block answers with
// one result per cycle on o_rsp, flagged by o_strobe for exactly one cycle;
// the receiver cannot hold results off, so it must take every strobed result.
// order is the terminator (0) at position width, then digits from the least
// significant one at width-1 downward (a zero value gives one '0'), then the
// pad character for the remaining left positions unless fill_char is zero.
// digits that do not fit are dropped, widths above MAX_WIDTH saturate, and a
// width of zero gives only the terminator. the final result has last set.
// a new request can be accepted only once the final result of the previous
// one has left. one divide-by-ten step per digit runs in a single shared
// reciprocal multiplier; its first quotient is registered when the request
// is accepted, and each digit is formed from the registered value and its
// quotient. busy is high from the cycle after acceptance through the last
// result.
// ----------------------------------------------------------------------------
module binary_to_padded_decimal
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH = 10
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    t_div_ctl div_ctl;   // load on accept, step per digit
    t_div_sts div_sts;   // current digit and end-of-value flag

    // sequencer: terminator, digit and pad phases
    bpd_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_sts    (div_sts),
        .o_ctl    (div_ctl),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // shared divide-by-ten unit holding the running value
    bpd_div10 u_div10 (
        .i_clk   (i_clk),
        .i_value (i_req.value),
        .i_ctl   (div_ctl),
        .o_sts   (div_sts)
    );

endmodule
